[hw/rtl/amcp_pkg.sv]
package amcp_pkg;

    // default width of the byte position counter
    localparam int OFFSET_BITS_DEFAULT = 40;

    // result queue depth: one byte can produce two results
    localparam int QUEUE_DEPTH = 3;

    // register indexes of the configuration port
    localparam logic [1:0] CFG_MEMBER_LIMIT  = 2'd0;
    localparam logic [1:0] CFG_DECODED_LIMIT = 2'd1;
    localparam logic [1:0] CFG_BASE_OFFSET   = 2'd2;

    // reset values of the configuration registers
    localparam logic [17:0] MEMBER_LIMIT_RESET  = 18'd100000;
    localparam logic [30:0] DECODED_LIMIT_RESET = 31'h1000_0000;
    localparam logic [39:0] BASE_OFFSET_RESET   = 40'd0;

    // largest member count the 17-bit counter holds
    localparam logic [16:0] COUNT_CAP = 17'h1_FFFF;

    // bytes in one size record
    localparam int RECORD_BYTES = 8;

    // archive status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SHORT     = 3'd1;
    localparam logic [2:0] ST_BAD_SIG   = 3'd2;
    localparam logic [2:0] ST_NEGATIVE  = 3'd3;
    localparam logic [2:0] ST_OVERSIZE  = 3'd4;
    localparam logic [2:0] ST_TOO_MANY  = 3'd5;
    localparam logic [2:0] ST_OVERFLOW  = 3'd6;

    // codec tags
    localparam logic CODEC_LZW  = 1'b0;
    localparam logic CODEC_HUFF = 1'b1;

    // smallest span that can hold a header and one record
    localparam int MIN_SPAN = 16;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } in_item_t;

    typedef struct packed {
        logic        is_status;
        logic [16:0] member_index;
        logic [40:0] record_offset;
        logic [30:0] packed_size;
        logic [30:0] orig_size;
        logic        codec;
        logic [2:0]  status;
        logic [39:0] archive_length;
        logic        last_of_item;
    } out_item_t;

    // queue writes for one accepted byte
    typedef struct packed {
        logic first;
        logic second;
    } push_t;

    // signature bytes "**++"
    function automatic logic [7:0] sig_char(input logic [1:0] idx);
        logic [7:0] c;
        c = idx[1] ? 8'h2B : 8'h2A;
        return c;
    endfunction

    // codec tag bytes "LZW " and "HUFF"
    function automatic logic [7:0] tag_char(input logic codec, input logic [1:0] idx);
        logic [7:0] c;
        if (codec == CODEC_LZW)
        begin
            unique case (idx)
                2'd0: c = 8'h4C;
                2'd1: c = 8'h5A;
                2'd2: c = 8'h57;
                default: c = 8'h20;
            endcase
        end
        else
        begin
            unique case (idx)
                2'd0: c = 8'h48;
                2'd1: c = 8'h55;
                default: c = 8'h46;
            endcase
        end
        return c;
    endfunction

endpackage

[hw/rtl/archive_member_chain_parser.sv]
// Member-chain archive parser. Bytes of an archive image come in one per transfer on the
// input channel; the block checks the "**++" signature and the "LZW "/"HUFF" codec tag,
// then walks the chain of 8-byte little-endian size records, skipping each member's
// compressed bytes, and sends one descriptor per member once its data has passed. The byte
// flagged final_byte closes the archive: a status result follows (with archive_length when
// the status is ok) and the parser returns to its reset state, so the next byte opens a new
// archive. A nonzero status means every earlier descriptor of that archive must be dropped.
// All parsing for a byte is done in the cycle it is accepted; results go to a three-entry
// queue, so a new byte is taken every cycle while the queue has room for two results.
// A byte can yield two results (a member and the final status); the single output port
// drains them one per cycle while out_ready is high. The user must write configuration
// registers via cfg_we/cfg_index/cfg_wdata only while the block is idle (not enforced).
module archive_member_chain_parser
#(
    parameter int OFFSET_BITS = amcp_pkg::OFFSET_BITS_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // byte input
    input  logic                 in_valid,
    output logic                 in_ready,
    input  amcp_pkg::in_item_t   in_data,
    // result output
    output logic                 out_valid,
    input  logic                 out_ready,
    output amcp_pkg::out_item_t  out_data,
    // configuration writes
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [39:0]          cfg_wdata
);

    // chain end may run one bit past the position counter
    localparam int CE_W  = OFFSET_BITS + 1;
    // wide enough for offsets and the reported 41-bit record offset
    localparam int SUM_W = (OFFSET_BITS + 1 > 41) ? OFFSET_BITS + 1 : 41;
    localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_RECORD,
        PH_DATA,
        PH_HALT
    } phase_t;

    // configuration
    logic [17:0] member_limit_reg;
    logic [30:0] decoded_limit_reg;
    logic [39:0] base_offset_reg;

    // parse state
    phase_t                 phase_reg,     phase_next;
    logic [OFFSET_BITS-1:0] pos_reg,       pos_next;
    logic [2:0]             fcnt_reg,      fcnt_next;
    logic [63:0]            shift_reg,     shift_next;
    logic [30:0]            remain_reg,    remain_next;
    logic [16:0]            count_reg,     count_next;
    logic                   codec_reg,     codec_next;
    logic [OFFSET_BITS-1:0] rec_start_reg, rec_start_next;
    logic [CE_W-1:0]        chain_end_reg, chain_end_next;
    logic [2:0]             err_reg,       err_next;

    logic        accept;
    logic        fin;
    logic        overflow;
    phase_t      phase_a;
    logic        hdr_ok;
    logic        mem_emit;
    logic        trunc;
    logic [30:0] mem_packed;
    logic [16:0] lim;
    logic [2:0]  stat;
    logic [SUM_W-1:0] rec_off_wide;
    logic [SUM_W-1:0] alen_wide;

    amcp_pkg::out_item_t desc_item;
    amcp_pkg::out_item_t stat_item;
    amcp_pkg::out_item_t item0;
    amcp_pkg::push_t     push;
    logic                space;

    assign in_ready = space;
    assign accept   = in_valid && in_ready;
    assign fin      = in_data.final_byte;
    assign overflow = pos_reg == POS_MAX;
    // a 17-bit counter caps the usable limit
    assign lim      = member_limit_reg[17] ? amcp_pkg::COUNT_CAP : member_limit_reg[16:0];

    // parse step for one byte
    always_comb
    begin
        phase_next     = phase_reg;
        fcnt_next      = fcnt_reg;
        shift_next     = shift_reg;
        remain_next    = remain_reg;
        codec_next     = codec_reg;
        rec_start_next = rec_start_reg;
        chain_end_next = chain_end_reg;
        err_next       = err_reg;
        hdr_ok         = 1'b0;
        mem_emit       = 1'b0;
        mem_packed     = '0;
        phase_a        = phase_reg;

        // position stuck at its top: halt with overflow
        if (overflow)
        begin
            if (err_next == amcp_pkg::ST_OK)
                err_next = amcp_pkg::ST_OVERFLOW;
            phase_a    = PH_HALT;
            phase_next = PH_HALT;
        end

        unique case (phase_a)
            PH_HEADER:
            begin
                if (fcnt_reg < 3'd4)
                    hdr_ok = in_data.data_byte == amcp_pkg::sig_char(fcnt_reg[1:0]);
                else if (fcnt_reg == 3'd4)
                begin
                    // first tag byte picks the codec
                    if (in_data.data_byte == amcp_pkg::tag_char(amcp_pkg::CODEC_LZW, 2'd0))
                    begin
                        hdr_ok     = 1'b1;
                        codec_next = amcp_pkg::CODEC_LZW;
                    end
                    else if (in_data.data_byte ==
                             amcp_pkg::tag_char(amcp_pkg::CODEC_HUFF, 2'd0))
                    begin
                        hdr_ok     = 1'b1;
                        codec_next = amcp_pkg::CODEC_HUFF;
                    end
                end
                else
                    hdr_ok = in_data.data_byte == amcp_pkg::tag_char(codec_reg, fcnt_reg[1:0]);

                if (!hdr_ok)
                begin
                    if (err_next == amcp_pkg::ST_OK)
                        err_next = amcp_pkg::ST_BAD_SIG;
                    phase_next = PH_HALT;
                end
                else if (fcnt_reg == 3'd7)
                begin
                    fcnt_next  = 3'd0;
                    phase_next = PH_RECORD;
                end
                else
                    fcnt_next = fcnt_reg + 3'd1;
            end

            PH_RECORD:
            begin
                if (fcnt_reg == 3'd0)
                    rec_start_next = pos_reg;
                shift_next = {in_data.data_byte, shift_reg[63:8]};
                fcnt_next  = fcnt_reg + 3'd1;
                // record complete: low word plain size, high word packed size
                if (fcnt_reg == 3'd7)
                begin
                    priority if (count_reg >= lim)
                    begin
                        if (err_next == amcp_pkg::ST_OK)
                            err_next = amcp_pkg::ST_TOO_MANY;
                        phase_next = PH_HALT;
                    end
                    else if (shift_next[31] || shift_next[63])
                    begin
                        if (err_next == amcp_pkg::ST_OK)
                            err_next = amcp_pkg::ST_NEGATIVE;
                        phase_next = PH_HALT;
                    end
                    else if (shift_next[30:0] > decoded_limit_reg)
                    begin
                        if (err_next == amcp_pkg::ST_OK)
                            err_next = amcp_pkg::ST_OVERSIZE;
                        phase_next = PH_HALT;
                    end
                    else if (shift_next[62:32] == 31'd0)
                    begin
                        // empty member: done at its record
                        mem_emit       = 1'b1;
                        mem_packed     = '0;
                        chain_end_next = CE_W'(rec_start_reg) + CE_W'(amcp_pkg::RECORD_BYTES);
                    end
                    else
                    begin
                        remain_next = shift_next[62:32];
                        phase_next  = PH_DATA;
                    end
                end
            end

            PH_DATA:
            begin
                remain_next = remain_reg - 31'd1;
                if (remain_next == 31'd0)
                begin
                    mem_emit       = 1'b1;
                    mem_packed     = shift_reg[62:32];
                    chain_end_next = CE_W'(pos_reg) + CE_W'(1);
                    phase_next     = PH_RECORD;
                end
            end

            PH_HALT:
            begin
                // nothing more until the final byte
            end

            default:
            begin
            end
        endcase

        pos_next = overflow ? pos_reg : pos_reg + OFFSET_BITS'(1);

        // final byte inside member data: emit the bytes really present
        trunc = fin && (phase_next == PH_DATA) && (remain_next != 31'd0) &&
                (err_next == amcp_pkg::ST_OK);
        if (trunc)
        begin
            mem_emit       = 1'b1;
            mem_packed     = shift_next[62:32] - remain_next;
            chain_end_next = CE_W'(pos_next);
        end

        count_next = count_reg + {16'd0, mem_emit};

        priority if (pos_next < OFFSET_BITS'(amcp_pkg::MIN_SPAN))
            stat = amcp_pkg::ST_SHORT;
        else if (err_next != amcp_pkg::ST_OK)
            stat = err_next;
        else if (count_next == 17'd0)
            stat = amcp_pkg::ST_SHORT;
        else
            stat = amcp_pkg::ST_OK;
    end

    assign rec_off_wide = SUM_W'(base_offset_reg) + SUM_W'(rec_start_reg);
    assign alen_wide    = SUM_W'(chain_end_next);

    // member descriptor
    always_comb
    begin
        desc_item                = '0;
        desc_item.is_status      = 1'b0;
        desc_item.member_index   = count_reg;
        desc_item.record_offset  = rec_off_wide[40:0];
        desc_item.packed_size    = mem_packed;
        desc_item.orig_size      = shift_next[30:0];
        desc_item.codec          = codec_next;
        desc_item.status         = amcp_pkg::ST_OK;
        desc_item.archive_length = '0;
        desc_item.last_of_item   = !fin;
    end

    // final archive status
    always_comb
    begin
        stat_item                = '0;
        stat_item.is_status      = 1'b1;
        stat_item.member_index   = count_next;
        stat_item.codec          = codec_next;
        stat_item.status         = stat;
        stat_item.archive_length = (stat == amcp_pkg::ST_OK) ? alen_wide[39:0] : 40'd0;
        stat_item.last_of_item   = 1'b1;
    end

    assign item0       = mem_emit ? desc_item : stat_item;
    assign push.first  = accept && (mem_emit || fin);
    assign push.second = accept && mem_emit && fin;

    amcp_result_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item0     (item0),
        .item1     (stat_item),
        .space     (space),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // parse state: cleared after the final byte of each archive
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            pos_reg       <= '0;
            fcnt_reg      <= '0;
            shift_reg     <= '0;
            remain_reg    <= '0;
            count_reg     <= '0;
            codec_reg     <= amcp_pkg::CODEC_LZW;
            rec_start_reg <= '0;
            chain_end_reg <= '0;
            err_reg       <= amcp_pkg::ST_OK;
        end
        else if (accept)
        begin
            if (fin)
            begin
                phase_reg     <= PH_HEADER;
                pos_reg       <= '0;
                fcnt_reg      <= '0;
                shift_reg     <= '0;
                remain_reg    <= '0;
                count_reg     <= '0;
                codec_reg     <= amcp_pkg::CODEC_LZW;
                rec_start_reg <= '0;
                chain_end_reg <= '0;
                err_reg       <= amcp_pkg::ST_OK;
            end
            else
            begin
                phase_reg     <= phase_next;
                pos_reg       <= pos_next;
                fcnt_reg      <= fcnt_next;
                shift_reg     <= shift_next;
                remain_reg    <= remain_next;
                count_reg     <= count_next;
                codec_reg     <= codec_next;
                rec_start_reg <= rec_start_next;
                chain_end_reg <= chain_end_next;
                err_reg       <= err_next;
            end
        end
    end

    // configuration registers, unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            member_limit_reg  <= amcp_pkg::MEMBER_LIMIT_RESET;
            decoded_limit_reg <= amcp_pkg::DECODED_LIMIT_RESET;
            base_offset_reg   <= amcp_pkg::BASE_OFFSET_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == amcp_pkg::CFG_MEMBER_LIMIT)
                member_limit_reg <= cfg_wdata[17:0];
            else if (cfg_index == amcp_pkg::CFG_DECODED_LIMIT)
                decoded_limit_reg <= cfg_wdata[30:0];
            else if (cfg_index == amcp_pkg::CFG_BASE_OFFSET)
                base_offset_reg <= cfg_wdata;
        end
    end

    // final byte returns the parser to its reset state
    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && fin) |=> (phase_reg == PH_HEADER && pos_reg == '0 && count_reg == '0))
        else $error("parser state not cleared after final byte");

    // first error wins until the archive ends
    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (err_reg != amcp_pkg::ST_OK && !(accept && fin)) |=> err_reg == $past(err_reg))
        else $error("error code changed within an archive");

    // halting only happens through an error
    a_halt_has_error: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_HALT |-> err_reg != amcp_pkg::ST_OK)
        else $error("halted without an error code");

    // data phase always has bytes left to skip
    a_data_remaining: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA |-> remain_reg != 31'd0)
        else $error("data phase with nothing remaining");

endmodule

[hw/rtl/amcp_result_queue.sv]
module amcp_result_queue
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  amcp_pkg::push_t      push,
    input  amcp_pkg::out_item_t  item0,
    input  amcp_pkg::out_item_t  item1,
    output logic                 space,
    output logic                 out_valid,
    input  logic                 out_ready,
    output amcp_pkg::out_item_t  out_data
);

    localparam int DEPTH = amcp_pkg::QUEUE_DEPTH;

    amcp_pkg::out_item_t q_reg  [DEPTH];
    amcp_pkg::out_item_t q_next [DEPTH];
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       pop;
    logic [1:0] keep;

    assign pop       = (cnt_reg != 2'd0) && out_ready;
    assign keep      = cnt_reg - {1'b0, pop};
    assign out_valid = cnt_reg != 2'd0;
    assign out_data  = q_reg[0];
    // room for two results, so a byte is never refused for lack of the second slot
    assign space     = cnt_reg < 2'(DEPTH - 1);

    always_comb
    begin
        for (int k = 0; k < DEPTH; k++)
        begin
            q_next[k] = q_reg[k];
            if (k < int'(keep))
            begin
                if (pop && (k + 1 < DEPTH))
                    q_next[k] = q_reg[k + 1];
            end
            else if ((k == int'(keep)) && push.first)
                q_next[k] = item0;
            else if ((k == int'(keep) + 1) && push.second)
                q_next[k] = item1;
        end
        cnt_next = keep + {1'b0, push.first} + {1'b0, push.second};
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < DEPTH; k++)
            q_reg[k] <= q_next[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'(DEPTH))
        else $error("result queue overfilled");

    a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
        push.second |-> push.first)
        else $error("second result written without first");

    a_push_needs_space: assert property (@(posedge clk) disable iff (!rst_n)
        push.first |-> space)
        else $error("result written while queue lacks room");

endmodule
